FILE: rtl/sorted_unique_set_defines.svh
// assertion macros for the sorted unique set checker
// expects signals clk and arst_n in the scope of each use
`ifndef SORTED_UNIQUE_SET_DEFINES_SVH
`define SORTED_UNIQUE_SET_DEFINES_SVH

// consequent checked in the same cycle
`define SUS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sorted_unique_set check failed");

// consequent checked in the next cycle
`define SUS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sorted_unique_set check failed");

`endif

FILE: rtl/sus_pkg.sv
// shared types and constants of the sorted unique set
// no dependencies
`timescale 1ns / 1ps

package sus_pkg;

	localparam int DATA_W         = 32;
	localparam int ACTION_W       = 2;
	localparam int STATUS_W       = 3;
	localparam int OCC_W          = 5;
	localparam int M_TDATA_W      = ((DATA_W + OCC_W + 7) / 8) * 8;
	localparam int CAPACITY_DEF   = 16;
	localparam int VALUE_BITS_DEF = 32;

	typedef enum logic [ACTION_W-1:0] {
		ACT_INSERT = 2'd0,
		ACT_DELETE = 2'd1,
		ACT_CLEAR  = 2'd2,
		ACT_DUMP   = 2'd3
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_DUP       = 3'd1,
		ST_NOT_FOUND = 3'd2,
		ST_FULL      = 3'd3,
		ST_EMPTY     = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_CMP,
		CELL_INS,
		CELL_DEL,
		CELL_ROT
	} cell_op_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_APPLY,
		S_DUMP
	} state_t;

endpackage

FILE: rtl/sus_cell.sv
// one slot of the sorted set: holds a value, compares it, shifts with its neighbors
// depends on sus_pkg
`timescale 1ns / 1ps

module sus_cell #(
	parameter int ELEM_W = 32
) (
	input  logic                     clk,
	input  sus_pkg::cell_op_t        op,
	input  logic [ELEM_W-1:0]        value,
	input  logic                     occ,
	input  logic                     left_lt,
	input  logic [ELEM_W-1:0]        left_entry,
	input  logic [ELEM_W-1:0]        right_entry,
	input  logic [ELEM_W-1:0]        head,
	input  logic                     is_end,
	output logic [ELEM_W-1:0]        entry,
	output logic                     lt,
	output logic                     eq
);
	import sus_pkg::*;

	logic [ELEM_W-1:0] entry_q;
	logic              lt_q;
	logic              eq_q;

	always_ff @(posedge clk) begin
		case (op)
			CELL_CMP: begin
				lt_q <= occ && ($signed(entry_q) < $signed(value));
				eq_q <= occ && (entry_q == value);
			end
			// slots at or above the insert point move up, the first one takes the value
			CELL_INS: begin
				if (!lt_q) begin
					entry_q <= left_lt ? value : left_entry;
				end
			end
			CELL_DEL: begin
				if (!lt_q) begin
					entry_q <= right_entry;
				end
			end
			// rotate the occupied slots down, the head wraps to the last one
			CELL_ROT: begin
				entry_q <= is_end ? head : right_entry;
			end
			default: begin
			end
		endcase
	end

	assign entry = entry_q;
	assign lt    = lt_q;
	assign eq    = eq_q;

endmodule

FILE: rtl/sus_chain.sv
// row of sus_cell slots with neighbor wiring and the found reduction
// depends on sus_pkg and sus_cell
`timescale 1ns / 1ps

module sus_chain #(
	parameter int CAPACITY = 16,
	parameter int ELEM_W   = 32,
	parameter int CNT_W    = 5
) (
	input  logic                 clk,
	input  sus_pkg::cell_op_t    op,
	input  logic [ELEM_W-1:0]    value,
	input  logic [CNT_W-1:0]     count,
	output logic                 found,
	output logic [ELEM_W-1:0]    head
);
	import sus_pkg::*;

	logic [ELEM_W-1:0]   entry [CAPACITY];
	logic [CAPACITY-1:0] lt;
	logic [CAPACITY-1:0] eq;
	logic [CAPACITY-1:0] occ;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic              left_lt;
		logic [ELEM_W-1:0] left_entry;
		logic [ELEM_W-1:0] right_entry;
		logic              is_end;

		assign occ[i] = CNT_W'(i) < count;

		if (i == 0) begin : g_first
			assign left_lt    = 1'b1;
			assign left_entry = '0;
		end else begin : g_mid
			assign left_lt    = lt[i-1];
			assign left_entry = entry[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_entry = entry[i];
			assign is_end      = occ[i];
		end else begin : g_inner
			assign right_entry = entry[i+1];
			assign is_end      = occ[i] && !occ[i+1];
		end

		sus_cell #(
			.ELEM_W(ELEM_W)
		) u_cell (
			.clk        (clk),
			.op         (op),
			.value      (value),
			.occ        (occ[i]),
			.left_lt    (left_lt),
			.left_entry (left_entry),
			.right_entry(right_entry),
			.head       (entry[0]),
			.is_end     (is_end),
			.entry      (entry[i]),
			.lt         (lt[i]),
			.eq         (eq[i])
		);
	end

	assign found = |eq;
	assign head  = entry[0];

endmodule

FILE: rtl/sorted_unique_set.sv
// top level of the sorted unique set: stream ports, sequencer, output register
// depends on sus_pkg and sus_chain
`timescale 1ns / 1ps

// Keeps up to CAPACITY distinct signed values in ascending order in a row of cells.
// Action in s_axis_tuser: insert, delete, clear, dump. Each cell compares its value
// with the operand in the accept cycle; the apply state, once the output register
// is free, resolves duplicate, not-found and full and shifts the cells. Dump
// then gives one value per cycle out of the head cell while the output register is
// free, and the occupied cells rotate back to their original order; an empty set
// gives a single result with the empty status. A result waits in the output
// register while the next item is accepted; the block stalls only when a new result
// is ready and the register is still held. No clearing pass at reset.
module sorted_unique_set #(
	parameter int CAPACITY   = sus_pkg::CAPACITY_DEF,
	parameter int VALUE_BITS = sus_pkg::VALUE_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [sus_pkg::DATA_W-1:0]       s_axis_tdata,  // value
	input  logic [sus_pkg::ACTION_W-1:0]     s_axis_tuser,  // action
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [sus_pkg::M_TDATA_W-1:0]    m_axis_tdata,  // element, occupancy, zero pad
	output logic [sus_pkg::STATUS_W-1:0]     m_axis_tuser,  // status
	output logic                             m_axis_tlast   // is_last
);
	import sus_pkg::*;

	localparam int ELEM_W = (VALUE_BITS < DATA_W) ? VALUE_BITS : DATA_W;
	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int PAD_W  = M_TDATA_W - DATA_W - OCC_W;

	state_t            state_q, state_d;
	action_t           action_q;
	logic [ELEM_W-1:0] value_q;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [CNT_W-1:0]  rem_q, rem_d;

	logic              m_valid_q;
	logic [DATA_W-1:0] elem_q;
	logic [OCC_W-1:0]  occ_q;
	status_t           status_q;
	logic              last_q;

	cell_op_t          cell_op;
	logic [ELEM_W-1:0] cell_value;
	logic              found;
	logic [ELEM_W-1:0] head;

	logic              s_accept;
	logic              slot_free;
	logic              full;
	logic              load_out;
	logic [DATA_W-1:0] out_elem;
	status_t           out_status;
	logic              out_last;

	assign s_accept  = s_axis_tvalid && s_axis_tready;
	assign slot_free = !m_valid_q || m_axis_tready;
	assign full      = count_q == CNT_W'(CAPACITY);

	sus_chain #(
		.CAPACITY(CAPACITY),
		.ELEM_W  (ELEM_W),
		.CNT_W   (CNT_W)
	) u_chain (
		.clk  (clk),
		.op   (cell_op),
		.value(cell_value),
		.count(count_q),
		.found(found),
		.head (head)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_accept) begin
					state_d = S_APPLY;
				end
			end
			S_APPLY: begin
				if (slot_free) begin
					state_d = (action_q == ACT_DUMP && count_q != '0) ? S_DUMP : S_IDLE;
				end
			end
			S_DUMP: begin
				if (slot_free && rem_q == CNT_W'(1)) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready = state_q == S_IDLE;
		cell_op       = CELL_HOLD;
		cell_value    = value_q;
		load_out      = 1'b0;
		out_elem      = DATA_W'($signed(value_q));
		out_status    = ST_OK;
		out_last      = 1'b1;
		count_d       = count_q;
		rem_d         = rem_q;
		unique case (state_q)
			S_IDLE: begin
				cell_value = s_axis_tdata[ELEM_W-1:0];
				if (s_accept) begin
					cell_op = CELL_CMP;
				end
			end
			S_APPLY: begin
				if (slot_free) begin
					load_out = 1'b1;
					case (action_q)
						ACT_INSERT: begin
							// duplicate wins over full
							if (found) begin
								out_status = ST_DUP;
							end else if (full) begin
								out_status = ST_FULL;
							end else begin
								cell_op = CELL_INS;
								count_d = count_q + CNT_W'(1);
							end
						end
						ACT_DELETE: begin
							if (found) begin
								cell_op = CELL_DEL;
								count_d = count_q - CNT_W'(1);
							end else begin
								out_status = ST_NOT_FOUND;
							end
						end
						ACT_CLEAR: begin
							count_d = '0;
						end
						default: begin
							if (count_q == '0) begin
								out_elem   = '0;
								out_status = ST_EMPTY;
							end else begin
								load_out = 1'b0;
								rem_d    = count_q;
							end
						end
					endcase
				end
			end
			S_DUMP: begin
				if (slot_free) begin
					load_out = 1'b1;
					cell_op  = CELL_ROT;
					out_elem = DATA_W'($signed(head));
					out_last = rem_q == CNT_W'(1);
					rem_d    = rem_q - CNT_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			rem_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			rem_q   <= rem_d;
			if (load_out) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			action_q <= action_t'(s_axis_tuser);
			value_q  <= s_axis_tdata[ELEM_W-1:0];
		end
		if (load_out) begin
			elem_q   <= out_elem;
			occ_q    <= OCC_W'(count_d);
			status_q <= out_status;
			last_q   <= out_last;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {PAD_W'(0), occ_q, elem_q};
	assign m_axis_tuser  = status_q;
	assign m_axis_tlast  = last_q;

endmodule

FILE: rtl/sus_checker.sv
// port-level checks for sorted_unique_set, attached by bind
// depends on sus_pkg and sorted_unique_set_defines.svh
`timescale 1ns / 1ps
`include "sorted_unique_set_defines.svh"

module sus_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_axis_tvalid,
	input logic                             s_axis_tready,
	input logic                             m_axis_tvalid,
	input logic                             m_axis_tready,
	input logic [sus_pkg::M_TDATA_W-1:0]    m_axis_tdata,
	input logic [sus_pkg::STATUS_W-1:0]     m_axis_tuser,
	input logic                             m_axis_tlast
);
	import sus_pkg::*;

	logic                          out_stall;
	logic [M_TDATA_W+STATUS_W:0]   out_bus;
	logic [OCC_W-1:0]              out_occ;
	logic [DATA_W-1:0]             out_elem;
	logic                          out_empty;
	logic                          out_reject;

	assign out_stall  = m_axis_tvalid && !m_axis_tready;
	assign out_bus    = {m_axis_tlast, m_axis_tuser, m_axis_tdata};
	assign out_occ    = m_axis_tdata[DATA_W+OCC_W-1:DATA_W];
	assign out_elem   = m_axis_tdata[DATA_W-1:0];
	assign out_empty  = m_axis_tvalid && m_axis_tuser == ST_EMPTY;
	assign out_reject = m_axis_tuser == ST_DUP || m_axis_tuser == ST_NOT_FOUND
		|| m_axis_tuser == ST_FULL;

	// a held result does not change
	`SUS_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid && $stable(out_bus))

	// one item in flight at a time
	`SUS_ASSERT_NEXT(a_one_in_flight, s_axis_tvalid && s_axis_tready, !s_axis_tready)

	// empty dump is a single result with nothing stored
	`SUS_ASSERT_NOW(a_empty_single, out_empty, m_axis_tlast && out_occ == '0 && out_elem == '0)

	// rejected insert or delete always ends its item
	`SUS_ASSERT_NOW(a_reject_last, m_axis_tvalid && out_reject, m_axis_tlast)

endmodule

bind sorted_unique_set sus_checker u_sus_checker (.*);

FILE: tb/tb_top.sv
// self-checking testbench of the sorted unique set: directed and random command streams
// a shadow copy of the sorted set predicts every result; depends on sus_pkg and sorted_unique_set
`timescale 1ns / 1ps

module tb_top;
	import sus_pkg::*;

	localparam int CAP        = sus_pkg::CAPACITY_DEF;
	localparam int IDLE_LIMIT = 4000;
	localparam int TAIL_CYCLES = 40;
	localparam int LONG_HOLD  = 300;

	typedef struct {
		action_t     action;
		logic [31:0] value;
		bit          wait_idle;
	} set_cmd_t;

	typedef struct {
		logic [31:0] element;
		logic        last;
		status_t     status;
		logic [4:0]  occ;
	} set_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [DATA_W-1:0] s_axis_tdata = '0;    // value
	logic [ACTION_W-1:0] s_axis_tuser = '0;  // action
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_axis_tdata;      // element, occupancy, zero pad
	logic [STATUS_W-1:0] m_axis_tuser;       // status
	logic m_axis_tlast;                      // is_last

	sorted_unique_set u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	set_cmd_t    cmd_backlog[$];
	set_result_t due_results[$];

	// shadow copy of the set, ascending, only the first shadow_count slots are valid
	logic signed [31:0] shadow_vals[CAP];
	int unsigned        shadow_count = 0;

	int cmds_total = 0;
	int cmds_accepted = 0;
	int results_checked = 0;
	int mismatches = 0;
	int dumps_seen = 0;
	int full_drops = 0;
	bit long_hold_done = 1'b0;

	function automatic int unsigned draw_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic void owe(logic [31:0] e, logic l, status_t s);
		set_result_t r;
		r.element = e;
		r.last    = l;
		r.status  = s;
		r.occ     = shadow_count[4:0];
		due_results.push_back(r);
	endfunction

	// value width equals the port width, so the operand is taken as is
	task automatic shadow_apply(set_cmd_t c);
		int unsigned pos;
		bit hit;
		logic signed [31:0] v;
		v = c.value;
		pos = 0;
		while (pos < shadow_count && shadow_vals[pos] < v)
			pos++;
		hit = (pos < shadow_count) && (shadow_vals[pos] == v);
		case (c.action)
			ACT_INSERT: begin
				// duplicate wins over full
				if (hit) begin
					owe(v, 1'b1, ST_DUP);
				end else if (shadow_count >= CAP) begin
					full_drops++;
					owe(v, 1'b1, ST_FULL);
				end else begin
					for (int i = shadow_count; i > pos; i--)
						shadow_vals[i] = shadow_vals[i-1];
					shadow_vals[pos] = v;
					shadow_count++;
					owe(v, 1'b1, ST_OK);
				end
			end
			ACT_DELETE: begin
				if (hit) begin
					for (int i = pos; i + 1 < shadow_count; i++)
						shadow_vals[i] = shadow_vals[i+1];
					shadow_count--;
					owe(v, 1'b1, ST_OK);
				end else begin
					owe(v, 1'b1, ST_NOT_FOUND);
				end
			end
			ACT_CLEAR: begin
				shadow_count = 0;
				owe(v, 1'b1, ST_OK);
			end
			default: begin
				dumps_seen++;
				if (shadow_count == 0) begin
					owe('0, 1'b1, ST_EMPTY);
				end else begin
					for (int i = 0; i < shadow_count; i++)
						owe(shadow_vals[i], (i + 1 == shadow_count), ST_OK);
				end
			end
		endcase
	endtask

	task automatic add_cmd(action_t a, logic [31:0] v, bit hold);
		set_cmd_t c;
		c.action    = a;
		c.value     = v;
		c.wait_idle = hold;
		cmd_backlog.push_back(c);
	endtask

	function automatic logic [31:0] pick_value();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r == 0) begin
			case ($urandom_range(0, 3))
				0: return 32'h8000_0000;
				1: return 32'h7fff_ffff;
				2: return 32'h0000_0000;
				default: return 32'hffff_ffff;
			endcase
		end
		if (r < 3)
			return $urandom_range(0, 40) - 20;
		return $urandom;
	endfunction

	// build up a set, often past capacity, with duplicates mixed in, then trim it
	task automatic fill_phase(bit hold);
		logic [31:0] pool[$];
		int n;
		n = $urandom_range(14, 22);
		for (int i = 0; i < n; i++)
			pool.push_back(pick_value());
		if ($urandom_range(0, 1))
			add_cmd(ACT_CLEAR, $urandom, hold);
		else
			add_cmd(ACT_DUMP, $urandom, hold);
		for (int i = 0; i < n; i++) begin
			add_cmd(ACT_INSERT, pool[i], 1'b0);
			if ($urandom_range(0, 5) == 0)
				add_cmd(ACT_INSERT, pool[$urandom_range(0, i)], 1'b0);
			if ($urandom_range(0, 9) == 0)
				add_cmd(ACT_DUMP, $urandom, 1'b0);
		end
		add_cmd(ACT_DUMP, $urandom, 1'b0);
		repeat ($urandom_range(2, 6))
			add_cmd(ACT_DELETE, pool[$urandom_range(0, n - 1)], 1'b0);
		add_cmd(ACT_DUMP, $urandom, 1'b0);
	endtask

	// driver: presents the backlog, predicts each item as it is accepted
	int unsigned tx_gap = 0;
	bit tx_quiet = 1'b0;
	set_cmd_t cur_cmd;

	always @(posedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				shadow_apply(cur_cmd);
				cmds_accepted <= cmds_accepted + 1;
				if (cmds_accepted % 40 == 39)
					tx_quiet = ($urandom_range(0, 2) == 0);
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (tx_gap != 0) begin
					tx_gap--;
					s_axis_tvalid <= 1'b0;
				end else if (cmd_backlog.size() == 0) begin
					s_axis_tvalid <= 1'b0;
				end else if (cmd_backlog[0].wait_idle && due_results.size() != 0) begin
					// hold off until the block has delivered everything owed
					s_axis_tvalid <= 1'b0;
				end else begin
					cur_cmd = cmd_backlog.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= cur_cmd.value;
					s_axis_tuser  <= cur_cmd.action;
					tx_gap = tx_quiet ? 0 : draw_gap();
				end
			end
		end
	end

	// receiver: random back-pressure plus one long hold while the sender keeps going
	int unsigned rx_gap = 0;
	int unsigned long_hold = 0;
	int unsigned rx_cycles = 0;
	bit rx_quiet = 1'b0;

	always @(posedge clk) begin
		int unsigned g;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			rx_cycles++;
			if (rx_cycles % 256 == 0)
				rx_quiet = ($urandom_range(0, 2) == 0);
			if (long_hold != 0) begin
				long_hold--;
				m_axis_tready <= 1'b0;
			end else if (!long_hold_done && cmds_accepted >= 120) begin
				long_hold_done = 1'b1;
				long_hold = LONG_HOLD - 1;
				m_axis_tready <= 1'b0;
			end else if (rx_gap != 0) begin
				rx_gap--;
				m_axis_tready <= 1'b0;
			end else begin
				g = (!rx_quiet && $urandom_range(0, 3) == 0) ? draw_gap() : 0;
				if (g != 0) begin
					rx_gap = g - 1;
					m_axis_tready <= 1'b0;
				end else begin
					m_axis_tready <= 1'b1;
				end
			end
		end
	end

	task automatic flag_error(string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch: %s", msg);
	endtask

	// monitor: every accepted result against the oldest one owed
	always @(posedge clk) begin
		set_result_t r;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (due_results.size() == 0) begin
				flag_error($sformatf("result with nothing owed: element %h status %0d last %0b",
					m_axis_tdata[DATA_W-1:0], m_axis_tuser, m_axis_tlast));
			end else begin
				r = due_results.pop_front();
				if (m_axis_tdata[DATA_W-1:0] !== r.element
						|| m_axis_tdata[DATA_W+OCC_W-1:DATA_W] !== r.occ
						|| m_axis_tdata[M_TDATA_W-1:DATA_W+OCC_W] !== '0
						|| m_axis_tuser !== r.status
						|| m_axis_tlast !== r.last)
					flag_error($sformatf(
						"result %0d exp elem %h occ %0d st %0d last %0b, got elem %h occ %0d st %0d last %0b pad %h",
						results_checked, r.element, r.occ, r.status, r.last,
						m_axis_tdata[DATA_W-1:0], m_axis_tdata[DATA_W+OCC_W-1:DATA_W],
						m_axis_tuser, m_axis_tlast, m_axis_tdata[M_TDATA_W-1:DATA_W+OCC_W]));
			end
			results_checked++;
		end
	end

	initial begin
		int idle;
		bit timed_out;
		bit hold;
		logic [31:0] pool[$];
		int n;
		int unsigned r;

		// directed: empty dump, extremes, duplicate, absent delete, clear
		add_cmd(ACT_DUMP,   $urandom,     1'b0);
		add_cmd(ACT_INSERT, 32'h0000_0000, 1'b0);
		add_cmd(ACT_INSERT, 32'h7fff_ffff, 1'b0);
		add_cmd(ACT_INSERT, 32'h8000_0000, 1'b0);
		add_cmd(ACT_INSERT, 32'hffff_ffff, 1'b0);
		add_cmd(ACT_INSERT, 32'h0000_0001, 1'b0);
		add_cmd(ACT_INSERT, 32'h0000_0000, 1'b0);
		add_cmd(ACT_DELETE, 32'h1234_5678, 1'b0);
		add_cmd(ACT_DUMP,   32'hffff_ffff, 1'b0);
		add_cmd(ACT_DELETE, 32'h8000_0000, 1'b0);
		add_cmd(ACT_DELETE, 32'h7fff_ffff, 1'b0);
		add_cmd(ACT_DELETE, 32'h7fff_ffff, 1'b0);
		add_cmd(ACT_DUMP,   32'h0000_0000, 1'b0);
		add_cmd(ACT_CLEAR,  32'hdead_beef, 1'b0);
		add_cmd(ACT_DELETE, 32'h0000_0000, 1'b0);
		add_cmd(ACT_DUMP,   32'h5555_aaaa, 1'b0);

		// random: first a full fill after a complete drain, then mixed phases
		fill_phase(1'b1);
		while (cmd_backlog.size() < 310) begin
			hold = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 9))
				0, 1, 2, 3: fill_phase(hold);
				4, 5, 6, 7, 8: begin
					pool.delete();
					n = $urandom_range(2, 8);
					for (int i = 0; i < n; i++)
						pool.push_back(pick_value());
					for (int i = 0; i < 3 * n; i++) begin
						r = $urandom_range(0, 19);
						if (r < 8)
							add_cmd(ACT_INSERT, ($urandom_range(0, 19) < 17) ?
								pool[$urandom_range(0, n - 1)] : $urandom, hold && i == 0);
						else if (r < 15)
							add_cmd(ACT_DELETE, ($urandom_range(0, 19) < 17) ?
								pool[$urandom_range(0, n - 1)] : $urandom, hold && i == 0);
						else if (r < 18)
							add_cmd(ACT_DUMP, $urandom, hold && i == 0);
						else if (r < 19)
							add_cmd(ACT_CLEAR, $urandom, hold && i == 0);
						else
							add_cmd(action_t'($urandom_range(0, 3)), $urandom, hold && i == 0);
					end
				end
				default: begin
					repeat (6)
						add_cmd(action_t'($urandom_range(0, 3)), $urandom, 1'b0);
				end
			endcase
		end
		cmds_total = cmd_backlog.size();

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		idle = 0;
		timed_out = 1'b0;
		while (1) begin
			@(posedge clk);
			if (cmds_accepted == cmds_total && due_results.size() == 0)
				break;
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle = 0;
			else
				idle++;
			if (idle >= IDLE_LIMIT) begin
				timed_out = 1'b1;
				break;
			end
		end

		if (timed_out) begin
			$display("timeout: %0d of %0d commands accepted, %0d results still owed",
				cmds_accepted, cmds_total, due_results.size());
			$display("tb: failure");
		end else begin
			repeat (TAIL_CYCLES) @(posedge clk);
			if (due_results.size() != 0)
				flag_error($sformatf("%0d results never arrived", due_results.size()));
			$display("summary: %0d commands (%0d dumps, %0d dropped on full), %0d results checked",
				cmds_total, dumps_seen, full_drops, results_checked);
			$display("summary: long output hold %0s, %0d mismatches",
				long_hold_done ? "done" : "not reached", mismatches);
			if (mismatches == 0)
				$display("tb: success");
			else
				$display("tb: failure");
		end
		$finish;
	end

endmodule
